// File: src/kfi_pkg.sv
// ----------------------------------------------------------------------------
// kfi_pkg: shared types and constants for the camera keyframe interpolator
// Key record, search token and controller states used across the block.
// ----------------------------------------------------------------------------
package kfi_pkg;

  // Largest table depth supported by default.
  localparam int KFI_MAX_KEYS = 64;

  // Number of blended fields per key.
  localparam int KFI_NFLD = 5;

  // Input operation codes.
  localparam logic KFI_OP_WRITE  = 1'b0;
  localparam logic KFI_OP_SAMPLE = 1'b1;

  // One camera key: time plus x, y, z, yaw, pitch.
  typedef struct packed {
    logic [31:0]                    time_v;
    logic [KFI_NFLD-1:0][31:0]      fld;
  } key_t;

  // Search token that walks down the cell row.
  typedef struct packed {
    logic        valid;
    logic [31:0] t;
    key_t        e;
    key_t        l;
    logic        done;
    logic        zero;
    logic        lo;
  } token_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DIV,
    ST_MUL,
    ST_ADD,
    ST_OUT
  } state_t;

endpackage

// File: src/kfi_if.sv
// ----------------------------------------------------------------------------
// kfi_in_if / kfi_out_if: valid-ready channels of the interpolator
// The input channel carries key writes and samples; the output carries results.
// ----------------------------------------------------------------------------
interface kfi_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [5:0]  key_index;
  logic [31:0] time_value;
  logic [31:0] pos_x;
  logic [31:0] pos_y;
  logic [31:0] pos_z;
  logic [31:0] yaw_in;
  logic [31:0] pitch_in;

  modport source (output valid, op, key_index, time_value, pos_x, pos_y, pos_z,
                  yaw_in, pitch_in, input ready);
  modport sink   (input valid, op, key_index, time_value, pos_x, pos_y, pos_z,
                  yaw_in, pitch_in, output ready);
endinterface

interface kfi_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] sample_time;
  logic [31:0] out_x;
  logic [31:0] out_y;
  logic [31:0] out_z;
  logic [31:0] out_yaw;
  logic [31:0] out_pitch;

  modport source (output valid, sample_time, out_x, out_y, out_z, out_yaw,
                  out_pitch, input ready);
  modport sink   (input valid, sample_time, out_x, out_y, out_z, out_yaw,
                  out_pitch, output ready);
endinterface

// File: src/kfi_cell.sv
// ----------------------------------------------------------------------------
// kfi_cell: one slot of the key table
// Holds one key and updates the passing search token with it.
// ----------------------------------------------------------------------------
module kfi_cell #(
  parameter int IDX = 0,
  parameter int IW  = 6
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  logic [5:0]         wr_idx,
  input  kfi_pkg::key_t      wr_key,
  input  logic [IW-1:0]      last,
  input  kfi_pkg::token_t    tok_in,
  output kfi_pkg::token_t    tok_out
);

  kfi_pkg::key_t   key_r;
  kfi_pkg::token_t tok_r;
  kfi_pkg::token_t tok_nxt;

  // Key storage, written when the broadcast index matches this slot.
  always_ff @(posedge clk) begin
    if (wr_en && (int'(wr_idx) == IDX)) begin
      key_r <= wr_key;
    end
  end

  // Token update: clamp at the ends, otherwise advance the earlier key or set the later one.
  always_comb begin
    tok_nxt = tok_in;
    if (IDX == 0) begin
      if ((last == '0) || (tok_in.t <= key_r.time_v)) begin
        tok_nxt.e    = key_r;
        tok_nxt.zero = 1'b1;
        tok_nxt.done = 1'b1;
        tok_nxt.lo   = 1'b1;
      end else begin
        tok_nxt.e = key_r;
      end
    end else if ((IDX <= int'(last)) && !tok_in.lo) begin
      if ((IDX == int'(last)) && (tok_in.t >= key_r.time_v)) begin
        tok_nxt.e    = key_r;
        tok_nxt.zero = 1'b1;
        tok_nxt.done = 1'b1;
      end else if (!tok_in.done) begin
        if ((IDX < int'(last)) && (key_r.time_v <= tok_in.t)) begin
          tok_nxt.e = key_r;
        end else begin
          tok_nxt.l    = key_r;
          tok_nxt.done = 1'b1;
        end
      end
    end
  end

  // Token register toward the next cell.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else begin
      tok_r.valid <= tok_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    tok_r.t    <= tok_nxt.t;
    tok_r.e    <= tok_nxt.e;
    tok_r.l    <= tok_nxt.l;
    tok_r.done <= tok_nxt.done;
    tok_r.zero <= tok_nxt.zero;
    tok_r.lo   <= tok_nxt.lo;
  end

  assign tok_out = tok_r;

endmodule

// File: src/kfi_div.sv
// ----------------------------------------------------------------------------
// kfi_div: restoring divider for the Q0.16 blend weight
// Computes floor(num * 65536 / den) one quotient bit per cycle, saturated.
// ----------------------------------------------------------------------------
module kfi_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic        busy,
  output logic [15:0] quo
);

  logic [32:0] rem_r,  rem_nxt;
  logic [15:0] quo_r,  quo_nxt;
  logic [4:0]  cnt_r,  cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [32:0] shl;

  // One restoring step per cycle.
  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    shl      = {rem_r[31:0], 1'b0};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 5'd0;
      rem_nxt  = {1'b0, num};
      quo_nxt  = '0;
      if (num >= den) begin
        // Weight saturates at its largest value.
        busy_nxt = 1'b0;
        quo_nxt  = 16'hFFFF;
      end
    end else if (busy_r) begin
      if (shl >= {1'b0, den}) begin
        rem_nxt = shl - {1'b0, den};
        quo_nxt = {quo_r[14:0], 1'b1};
      end else begin
        rem_nxt = shl;
        quo_nxt = {quo_r[14:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd15) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign busy = busy_r;
  assign quo  = quo_r;

endmodule

// File: src/camera_keyframe_interpolator.sv
// ----------------------------------------------------------------------------
// camera_keyframe_interpolator: linear camera key interpolation
// Key table held in a row of cells; samples search, divide and blend.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake      Payload
//  in_ch    in   valid/ready    op, key_index, time_value, pos_x/y/z, yaw, pitch
//  out_ch   out  valid/ready    sample_time, out_x/y/z, out_yaw, out_pitch
//  cfg      in   cfg_we         cfg_wdata (key_count)
//
//  A sample walks its token down the cell row, runs the divider, takes five
//  multiply/add blend steps on one shared multiplier and then loads the result
//  register. Reset is synchronous and active low; it clears control only.
//  A held result stalls the block only at the point of loading the next one.
// ----------------------------------------------------------------------------
module camera_keyframe_interpolator #(
  parameter int MAX_KEYS = kfi_pkg::KFI_MAX_KEYS
) (
  input  logic      clk,
  input  logic      rst_n,
  kfi_in_if.sink    in_ch,
  kfi_out_if.source out_ch,
  input  logic      cfg_we,
  input  logic [6:0] cfg_wdata
);

  localparam int IW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;

  kfi_pkg::state_t state_r, state_nxt;
  logic [6:0]      count_r;
  logic [IW-1:0]   last;
  kfi_pkg::key_t   wr_key;
  logic            wr_en;
  logic            in_acc;
  kfi_pkg::token_t chain [MAX_KEYS+1];
  kfi_pkg::token_t tok_r;
  logic            div_start;
  logic            div_start_q;
  logic            div_ok;
  logic            div_busy;
  logic [15:0]     div_quo;
  logic [31:0]     div_num;
  logic [31:0]     div_den;
  logic [15:0]     w_r;
  logic [2:0]      fld_r;
  logic signed [49:0] prod_r;
  logic [31:0]     res_r [kfi_pkg::KFI_NFLD];
  logic signed [32:0] diff;
  logic signed [49:0] prod;
  logic [31:0]     sum;
  logic            out_valid_r;
  logic [31:0]     out_t_r;
  logic [31:0]     out_f_r [kfi_pkg::KFI_NFLD];
  logic            out_load;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 7'd1;
    end else if (cfg_we) begin
      count_r <= cfg_wdata;
    end
  end

  // Index of the last valid key, with the count clamped to 1..MAX_KEYS.
  always_comb begin
    if (count_r == 7'd0) begin
      last = '0;
    end else if (int'(count_r) > MAX_KEYS) begin
      last = IW'(MAX_KEYS - 1);
    end else begin
      last = IW'(count_r - 7'd1);
    end
  end

  // Input acceptance and key broadcast.
  assign in_ch.ready = (state_r == kfi_pkg::ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign wr_en       = in_acc && (in_ch.op == kfi_pkg::KFI_OP_WRITE);

  always_comb begin
    wr_key.time_v = in_ch.time_value;
    wr_key.fld[0] = in_ch.pos_x;
    wr_key.fld[1] = in_ch.pos_y;
    wr_key.fld[2] = in_ch.pos_z;
    wr_key.fld[3] = in_ch.yaw_in;
    wr_key.fld[4] = in_ch.pitch_in;
  end

  // Token launched into the first cell for a sample item.
  always_comb begin
    chain[0]       = '0;
    chain[0].valid = in_acc && (in_ch.op == kfi_pkg::KFI_OP_SAMPLE);
    chain[0].t     = in_ch.time_value;
  end

  // Row of key cells.
  for (genvar i = 0; i < MAX_KEYS; i++) begin : g_cell
    kfi_cell #(.IDX(i), .IW(IW)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .wr_en   (wr_en),
      .wr_idx  (in_ch.key_index),
      .wr_key  (wr_key),
      .last    (last),
      .tok_in  (chain[i]),
      .tok_out (chain[i+1])
    );
  end

  // Capture the finished token.
  always_ff @(posedge clk) begin
    if (chain[MAX_KEYS].valid) begin
      tok_r <= chain[MAX_KEYS];
    end
  end

  // Weight divider.
  assign div_num   = tok_r.t - tok_r.e.time_v;
  assign div_den   = tok_r.l.time_v - tok_r.e.time_v;
  assign div_start = (state_r == kfi_pkg::ST_SEARCH) && chain[MAX_KEYS].valid;

  kfi_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start_q),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quo   (div_quo)
  );

  // The divider start is registered together with the token capture, so the divider sees the captured token.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_start_q <= 1'b0;
    end else begin
      div_start_q <= div_start;
    end
  end

  assign div_ok = !tok_r.zero && (tok_r.l.time_v > tok_r.e.time_v)
                  && (tok_r.t >= tok_r.e.time_v);

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      kfi_pkg::ST_IDLE: begin
        if (chain[0].valid) state_nxt = kfi_pkg::ST_SEARCH;
      end
      kfi_pkg::ST_SEARCH: begin
        if (chain[MAX_KEYS].valid) state_nxt = kfi_pkg::ST_DIV;
      end
      kfi_pkg::ST_DIV: begin
        if (!div_start_q && !div_busy) state_nxt = kfi_pkg::ST_MUL;
      end
      kfi_pkg::ST_MUL: state_nxt = kfi_pkg::ST_ADD;
      kfi_pkg::ST_ADD: begin
        if (fld_r == 3'(kfi_pkg::KFI_NFLD - 1)) state_nxt = kfi_pkg::ST_OUT;
        else                                    state_nxt = kfi_pkg::ST_MUL;
      end
      kfi_pkg::ST_OUT: begin
        if (out_load) state_nxt = kfi_pkg::ST_IDLE;
      end
      default: state_nxt = kfi_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= kfi_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Output-side control: result register loads when free.
  always_comb begin
    out_load = (state_r == kfi_pkg::ST_OUT) && (!out_valid_r || out_ch.ready);
  end

  // Weight and field counter.
  always_ff @(posedge clk) begin
    if (state_r == kfi_pkg::ST_DIV && state_nxt == kfi_pkg::ST_MUL) begin
      w_r <= div_ok ? div_quo : 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fld_r <= '0;
    end else if (state_r == kfi_pkg::ST_DIV) begin
      fld_r <= '0;
    end else if (state_r == kfi_pkg::ST_ADD) begin
      fld_r <= fld_r + 3'd1;
    end
  end

  // Shared blend datapath: multiply, register, then shift and add.
  always_comb begin
    diff = $signed({tok_r.l.fld[fld_r][31], tok_r.l.fld[fld_r]})
         - $signed({tok_r.e.fld[fld_r][31], tok_r.e.fld[fld_r]});
    prod = diff * $signed({1'b0, w_r});
    sum  = tok_r.e.fld[fld_r] + 32'(prod_r >>> 16);
  end

  always_ff @(posedge clk) begin
    if (state_r == kfi_pkg::ST_MUL) begin
      prod_r <= prod;
    end
    if (state_r == kfi_pkg::ST_ADD) begin
      res_r[fld_r] <= sum;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_t_r <= tok_r.t;
      out_f_r <= res_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.sample_time = out_t_r;
  assign out_ch.out_x       = out_f_r[0];
  assign out_ch.out_y       = out_f_r[1];
  assign out_ch.out_z       = out_f_r[2];
  assign out_ch.out_yaw     = out_f_r[3];
  assign out_ch.out_pitch   = out_f_r[4];

endmodule

// File: src/kfi_checker.sv
// ----------------------------------------------------------------------------
// kfi_checker: port-level checks for the camera keyframe interpolator
// Watches the channel ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
module kfi_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_op,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_time
);

  // No result appears right after reset.
  a_rst_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A sample item closes the input for the next cycle.
  a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_op) |=> !in_ready)
    else $error("input ready right after a sample item");

  // A stalled result is held.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_time)))
    else $error("stalled result changed");

  // A key write never produces a result in the next cycle from an idle output.
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !in_op && !out_valid) |=> !out_valid)
    else $error("result after a key write");

endmodule

bind camera_keyframe_interpolator kfi_checker u_kfi_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_op     (in_ch.op),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_time  (out_ch.sample_time)
);

// File: tb/sv/tb_camera_keyframe_interpolator.sv
// ----------------------------------------------------------------------------
// tb_camera_keyframe_interpolator: self-checking bench for the interpolator
// Fills the key table, samples at edge and interior times under random
// valid/ready gaps, and compares every result with a built-in predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_camera_keyframe_interpolator;

  localparam int NKEYS      = 64;
  localparam int DRAIN_WAIT = 200;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic        op;
    logic [5:0]  key_index;
    logic [31:0] time_value;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] yaw_in;
    logic [31:0] pitch_in;
  } kf_item_t;

  typedef struct packed {
    logic [31:0] sample_time;
    logic [4:0][31:0] fld;
  } cam_sample_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [6:0] cfg_wdata;

  kfi_in_if  in_ch ();
  kfi_out_if out_ch ();

  camera_keyframe_interpolator uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // Predictor state: a shadow of the key table and of key_count.
  logic [31:0] shadow_time [NKEYS];
  logic [4:0][31:0] shadow_fld [NKEYS];
  logic [6:0]  shadow_count;
  bit          written [NKEYS];

  kf_item_t    pending_items[$];
  cam_sample_t expected_samples[$];
  int          mismatch_count;
  int          sample_count;
  int          write_count;
  longint      cycle_count;
  bit          in_quiet;
  bit          out_quiet;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Blend one field: a + floor((b - a) * w / 65536).
  function automatic logic [31:0] blend_field(logic [31:0] a, logic [31:0] b,
                                              logic [15:0] w);
    longint sa;
    longint d;
    longint p;
    longint q;
    sa = longint'($signed(a));
    d  = longint'($signed(b)) - sa;
    p  = d * longint'({1'b0, w});
    q  = p >>> 16;
    return 32'(sa + q);
  endfunction

  // Predict the result of a sample at time t from the shadow table.
  function automatic cam_sample_t predict_sample(logic [31:0] t);
    cam_sample_t r;
    int last;
    int e;
    int l;
    logic [63:0] quo;
    logic [15:0] w;
    last = (shadow_count == 0) ? 0 :
           (shadow_count > NKEYS) ? NKEYS - 1 : shadow_count - 1;
    w = '0;
    if (t <= shadow_time[0]) begin
      e = 0;
      l = 0;
    end else if (t >= shadow_time[last]) begin
      e = last;
      l = last;
    end else begin
      e = 0;
      while (e + 1 < last && shadow_time[e+1] <= t) e++;
      l = e + 1;
      if (shadow_time[l] > shadow_time[e] && t >= shadow_time[e]) begin
        quo = {32'(t - shadow_time[e]), 16'h0} / (shadow_time[l] - shadow_time[e]);
        w = (quo > 64'hFFFF) ? 16'hFFFF : quo[15:0];
      end
    end
    r.sample_time = t;
    for (int f = 0; f < 5; f++)
      r.fld[f] = blend_field(shadow_fld[e][f], shadow_fld[l][f], w);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what,
             got, want);
    mismatch_count++;
  endtask

  task automatic add_key(int slot, logic [31:0] t);
    kf_item_t it;
    it.op = kfi_pkg::KFI_OP_WRITE;
    it.key_index = 6'(slot);
    it.time_value = t;
    it.pos_x = $urandom;
    it.pos_y = $urandom;
    it.pos_z = $urandom;
    it.yaw_in = $urandom;
    it.pitch_in = $urandom;
    pending_items.push_back(it);
  endtask

  task automatic add_sample(logic [31:0] t);
    kf_item_t it;
    it = '{default: '0};
    it.op = kfi_pkg::KFI_OP_SAMPLE;
    it.key_index = 6'($urandom);
    it.time_value = t;
    it.pos_x = $urandom;
    it.pos_y = $urandom;
    it.pos_z = $urandom;
    it.yaw_in = $urandom;
    it.pitch_in = $urandom;
    pending_items.push_back(it);
  endtask

  // Wait until every queued item is accepted and every result has come back.
  task automatic drain();
    while (pending_items.size() != 0 || in_ch.valid || expected_samples.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_count_reg(logic [6:0] v);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    shadow_count = v;
  endtask

  // Pick a sample time near the written keys, or anywhere.
  function automatic logic [31:0] pick_time(int n);
    int k;
    k = $urandom_range(n - 1, 0);
    case ($urandom_range(5, 0))
      0: return shadow_time[k];
      1: return shadow_time[k] + $urandom_range(3, 0) - 1;
      2: return $urandom;
      default: begin
        if (k + 1 < n && shadow_time[k+1] > shadow_time[k])
          return shadow_time[k] + $urandom_range(shadow_time[k+1] - shadow_time[k], 0);
        return shadow_time[k] + $urandom_range(1000, 0);
      end
    endcase
  endfunction

  // Driver: presents queued items, changes inputs at the falling edge.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_ch.ready) begin
      // Hold the offered item.
    end else if (pending_items.size() != 0 && (in_quiet || $urandom_range(99, 0) >= 34))
    begin
      kf_item_t it;
      it = pending_items.pop_front();
      in_ch.valid      <= 1'b1;
      in_ch.op         <= it.op;
      in_ch.key_index  <= it.key_index;
      in_ch.time_value <= it.time_value;
      in_ch.pos_x      <= it.pos_x;
      in_ch.pos_y      <= it.pos_y;
      in_ch.pos_z      <= it.pos_z;
      in_ch.yaw_in     <= it.yaw_in;
      in_ch.pitch_in   <= it.pitch_in;
    end else begin
      in_ch.valid <= 1'b0;
    end
    out_ch.ready <= rst_n && (out_quiet || $urandom_range(99, 0) >= 34);
  end

  // Monitor: predicts on accepted inputs and checks accepted results.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
    end
    if (rst_n && in_ch.valid && in_ch.ready) begin
      if (in_ch.op == kfi_pkg::KFI_OP_WRITE) begin
        shadow_time[in_ch.key_index] = in_ch.time_value;
        shadow_fld[in_ch.key_index] = {in_ch.pitch_in, in_ch.yaw_in, in_ch.pos_z,
                                       in_ch.pos_y, in_ch.pos_x};
        written[in_ch.key_index] = 1'b1;
        write_count++;
      end else begin
        expected_samples.push_back(predict_sample(in_ch.time_value));
        sample_count++;
      end
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_samples.size() == 0) begin
        report_mismatch("unexpected result time", out_ch.sample_time, '0);
      end else begin
        cam_sample_t w;
        cam_sample_t g;
        w = expected_samples.pop_front();
        g.sample_time = out_ch.sample_time;
        g.fld = {out_ch.out_pitch, out_ch.out_yaw, out_ch.out_z, out_ch.out_y,
                 out_ch.out_x};
        if (g.sample_time != w.sample_time)
          report_mismatch("sample_time", g.sample_time, w.sample_time);
        if (g.fld[0] != w.fld[0]) report_mismatch("out_x", g.fld[0], w.fld[0]);
        if (g.fld[1] != w.fld[1]) report_mismatch("out_y", g.fld[1], w.fld[1]);
        if (g.fld[2] != w.fld[2]) report_mismatch("out_z", g.fld[2], w.fld[2]);
        if (g.fld[3] != w.fld[3]) report_mismatch("out_yaw", g.fld[3], w.fld[3]);
        if (g.fld[4] != w.fld[4]) report_mismatch("out_pitch", g.fld[4], w.fld[4]);
      end
    end
  end

  // Stimulus sequence.
  initial begin
    int counts[5];
    logic [31:0] t;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.op = kfi_pkg::KFI_OP_WRITE;
    in_ch.key_index = '0;
    in_ch.time_value = '0;
    in_ch.pos_x = '0;
    in_ch.pos_y = '0;
    in_ch.pos_z = '0;
    in_ch.yaw_in = '0;
    in_ch.pitch_in = '0;
    out_ch.ready = 1'b0;
    shadow_count = 7'd1;
    mismatch_count = 0;
    sample_count = 0;
    write_count = 0;
    cycle_count = 0;
    in_quiet = 1'b0;
    out_quiet = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: one key at reset count, then two keys with extreme values,
    // coincident keys and queries at and beyond both ends.
    begin
      kf_item_t it;
      it.op = kfi_pkg::KFI_OP_WRITE;
      it.key_index = 6'd0;
      it.time_value = 32'h0001_0000;
      it.pos_x = 32'h8000_0000;
      it.pos_y = 32'h7FFF_FFFF;
      it.pos_z = 32'hFFFF_FFFF;
      it.yaw_in = 32'h0;
      it.pitch_in = 32'h7FFF_FFFF;
      pending_items.push_back(it);
      add_sample(32'h0);
      add_sample(32'hFFFF_FFFF);
      it.key_index = 6'd1;
      it.time_value = 32'hFFFF_FFFF;
      it.pos_x = 32'h7FFF_FFFF;
      it.pos_y = 32'h8000_0000;
      it.pos_z = 32'h0000_0001;
      it.yaw_in = 32'hFFFF_FFFF;
      it.pitch_in = 32'h8000_0000;
      pending_items.push_back(it);
      it.key_index = 6'd63;
      it.time_value = 32'h5555_AAAA;
      pending_items.push_back(it);
    end
    drain();
    write_count_reg(7'd2);
    add_sample(32'h0001_0000);
    add_sample(32'h0001_0001);
    add_sample(32'h8000_0000);
    add_sample(32'hFFFF_FFFE);
    add_sample(32'hFFFF_FFFF);
    add_key(1, 32'h0001_0000);   // coincident with key 0
    add_sample(32'h0001_0000);
    add_sample(32'h0000_FFFF);
    add_sample(32'h0002_0000);
    drain();

    // Random phases: fill a sorted table, then sample; vary key_count
    // including both extremes and the out-of-range values.
    counts = '{64, 3, 17, 0, 127};
    for (int ph = 0; ph < 5; ph++) begin
      int n;
      n = (counts[ph] == 0) ? 1 : (counts[ph] > 64 ? 64 : counts[ph]);
      in_quiet = (ph == 2);
      out_quiet = (ph == 2);
      t = $urandom_range(1000, 0);
      for (int k = 0; k < NKEYS; k++) begin
        if (k < n || !written[k]) begin
          if ($urandom_range(7, 0) != 0) t = t + $urandom_range(32'h0400_0000, 1);
          add_key(k, t);
        end
      end
      drain();
      write_count_reg(7'(counts[ph]));
      for (int i = 0; i < 80; i++) begin
        if ($urandom_range(15, 0) == 0)
          add_key($urandom_range(n - 1, 0), shadow_time[$urandom_range(n - 1, 0)]);
        else
          add_sample(pick_time(n));
      end
      drain();
    end
    write_count_reg(7'd64);

    $display("covered %0d key writes and %0d samples over several key counts",
             write_count, sample_count);
    if (mismatch_count == 0 && expected_samples.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatch_count,
               expected_samples.size());
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
src/kfi_pkg.sv
src/kfi_if.sv
src/kfi_cell.sv
src/kfi_div.sv
src/camera_keyframe_interpolator.sv
src/kfi_checker.sv
tb/sv/tb_camera_keyframe_interpolator.sv
